FILE: sv/mandelbrot_escape_time_pixel_macros.svh
// Assertion helpers for the top-level RTL file. They expect clk_i and rst_ni in scope.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH

// Same-cycle implication, checked out of reset
`define MEP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define MEP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/mep_pkg.sv
`default_nettype none

package mep_pkg;

  // Field widths fixed by the item formats
  localparam int InW     = 32;
  localparam int CfgW    = 16;
  localparam int CntOutW = 16;
  localparam int GrayW   = 8;

  // Fixed-point and mapping constants
  localparam int InFrac      = 29;
  localparam int IntBits     = 12;
  localparam int EscapeLimit = 16;
  localparam int GrayMax     = 255;

  // Register reset values
  localparam int MaxIterReset = 100;
  localparam int GrayLoReset  = 0;
  localparam int GrayHiReset  = 100;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_MAX_ITER  = 2'd0,
    CFG_GRAY_LOW  = 2'd1,
    CFG_GRAY_HIGH = 2'd2
  } cfg_idx_e;

  // Phases of one iteration pass: issue three products, then collect them
  localparam logic [2:0] PhIssueRr = 3'd0;
  localparam logic [2:0] PhIssueIi = 3'd1;
  localparam logic [2:0] PhTakeRr  = 3'd3;
  localparam logic [2:0] PhTakeIi  = 3'd4;
  localparam logic [2:0] PhLast    = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ITER,
    ST_GRAY,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [InW-1:0] c_real;
    logic signed [InW-1:0] c_imag;
  } in_item_t;

  typedef struct packed {
    logic [CntOutW-1:0] iter_count;
    logic               escaped;
    logic [GrayW-1:0]   gray_level;
  } out_item_t;

  // Status of the gray-level divider
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [GrayW-1:0] quot;
  } div_stat_t;

endpackage

`default_nettype wire

FILE: sv/mep_mul.sv
`default_nettype none

// Signed ZW x ZW multiplier, split into four half-width partial products.
// Three register stages: partials, middle sum, full product.
module mep_mul #(
  parameter int ZW = 41
) (
  input  wire logic                   clk_i,
  input  wire logic signed [ZW-1:0]   a_i,
  input  wire logic signed [ZW-1:0]   b_i,
  output      logic signed [2*ZW-1:0] p_o
);

  localparam int H  = (ZW + 1) / 2;
  localparam int LW = ZW - H;
  localparam int PW = 2 * ZW;

  logic signed [H:0]     al, ah, bl, bh;
  logic signed [2*H+1:0] ll_q, lh_q, hl_q, hh_q;
  logic signed [2*H+2:0] mid_q;
  logic signed [PW-1:0]  cat_q;
  logic signed [PW-1:0]  p_q;

  // Split operands: low halves unsigned, high halves signed
  assign al = {1'b0, a_i[H-1:0]};
  assign bl = {1'b0, b_i[H-1:0]};
  assign ah = {{(H+1-LW){a_i[ZW-1]}}, a_i[ZW-1:H]};
  assign bh = {{(H+1-LW){b_i[ZW-1]}}, b_i[ZW-1:H]};

  // Stage 1: partial products
  always_ff @(posedge clk_i) begin
    ll_q <= al * bl;
    lh_q <= al * bh;
    hl_q <= ah * bl;
    hh_q <= ah * bh;
  end

  // Stage 2: cross terms summed, outer terms packed side by side
  always_ff @(posedge clk_i) begin
    mid_q <= (2*H+3)'(lh_q) + (2*H+3)'(hl_q);
    cat_q <= {hh_q[PW-2*H-1:0], ll_q[2*H-1:0]};
  end

  // Stage 3: fold in the cross terms
  always_ff @(posedge clk_i) begin
    p_q <= cat_q + (PW'(mid_q) <<< H);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

FILE: sv/mep_div.sv
`default_nettype none

// Restoring divider for the gray level: floor(255*num / den), num <= den.
// One quotient bit a cycle, most significant first.
module mep_div
  import mep_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [CfgW-1:0] num_i,
  input  wire logic [CfgW-1:0] den_i,
  output      div_stat_t       stat_o
);

  localparam int NW = CfgW + GrayW;
  localparam int SW = $clog2(GrayW);

  logic [CfgW-1:0]  rem_q, d_q;
  logic [GrayW-1:0] nlow_q, q_q;
  logic [SW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [NW-1:0]    n_scaled;
  logic [CfgW:0]    rem_s, rem_sub;
  logic             ge;

  // 255*num as (num << 8) - num
  assign n_scaled = {num_i, {GrayW{1'b0}}} - NW'(num_i);

  // Trial subtract on the shifted remainder
  assign rem_s   = {rem_q, nlow_q[GrayW-1]};
  assign rem_sub = rem_s - {1'b0, d_q};
  assign ge      = (rem_s >= {1'b0, d_q});

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= SW'(GrayW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - SW'(1);
        end
      end
    end
  end

  // Remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      d_q    <= den_i;
      rem_q  <= n_scaled[NW-1:GrayW];
      nlow_q <= n_scaled[GrayW-1:0];
      q_q    <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? rem_sub[CfgW-1:0] : rem_s[CfgW-1:0];
      nlow_q <= {nlow_q[GrayW-2:0], 1'b0};
      q_q    <= {q_q[GrayW-2:0], ge};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign stat_o.quot = q_q;

endmodule

`default_nettype wire

FILE: sv/mandelbrot_escape_time_pixel.sv
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_stall_o  in_item_i  (c_real, c_imag)
// out      output     out_valid_o / out_stall_i out_item_o (iter_count, escaped, gray_level)
// cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// The gray level needs the divider only when the point escaped with a count inside
// distinct bounds; the default pass limit is 100.
// Each pass runs three products through the one shared 3-stage multiplier.
// A new item is taken only in idle; a finished result waits in the output register.
// Reset returns the registers to 100 / 0 / 100 and leaves the block idle.
// A stalled output holds its item; the next item's work runs up to that register.
`default_nettype none
`include "mandelbrot_escape_time_pixel_macros.svh"

module mandelbrot_escape_time_pixel
  import mep_pkg::*;
#(
  parameter int FRAC_BITS  = 29,
  parameter int COUNT_BITS = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output      logic            in_stall_o,
  input  wire in_item_t        in_item_i,
  output      logic            out_valid_o,
  input  wire logic            out_stall_i,
  output      out_item_t       out_item_o,
  input  wire logic            cfg_valid_i,
  output      logic            cfg_ready_o,
  input  wire logic [1:0]      cfg_index_i,
  input  wire logic [CfgW-1:0] cfg_data_i
);

  localparam int ZW  = FRAC_BITS + IntBits;
  localparam int PW  = 2 * ZW;
  localparam int CB  = COUNT_BITS;
  localparam int GW  = (CB > CfgW) ? CB : CfgW;
  localparam int SHL = (FRAC_BITS >= InFrac) ? FRAC_BITS - InFrac : 0;
  localparam int SHR = (FRAC_BITS >= InFrac) ? 0 : InFrac - FRAC_BITS;
  localparam int CW  = ZW + InW;
  localparam logic signed [ZW-1:0] EscLim = ZW'(EscapeLimit) << FRAC_BITS;
  localparam logic signed [ZW-1:0] NegLim = -EscLim;

  state_e state_q, state_d;
  logic [2:0] ph_q, ph_d;
  logic [CB-1:0] k_q, k_d, k_inc;
  logic [CB-1:0] max_iter_q;
  logic [CfgW-1:0] glo_q, ghi_q;
  logic signed [ZW-1:0] zr_q, zr_d, zi_q, zi_d, cr_q, cr_d, ci_q, ci_d;
  logic signed [ZW-1:0] p0_q, p0_d, p1_q, p1_d;
  logic esc_q, esc_d;
  logic [GrayW-1:0] gray_q, gray_d;
  out_item_t out_q, out_d;
  logic out_valid_q, out_valid_d;

  logic signed [CW-1:0] cr_w, ci_w;
  logic signed [ZW-1:0] mul_a, mul_b, re_n, im_n, prod_re, prod_im;
  logic signed [PW-1:0] prod;
  logic esc_n, last_k, accept, out_free;
  logic [CfgW-1:0] lo, hi, div_num, div_den;
  logic gray_out_range, gray_div, div_start;
  div_stat_t div_stat;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // Rescale the input point to the iteration format
  assign cr_w = (CW'(in_item_i.c_real) <<< SHL) >>> SHR;
  assign ci_w = (CW'(in_item_i.c_imag) <<< SHL) >>> SHR;

  // Shared multiplier: z_re*z_re, z_im*z_im, then z_re*z_im
  always_comb begin
    case (ph_q)
      PhIssueRr: begin
        mul_a = zr_q;
        mul_b = zr_q;
      end
      PhIssueIi: begin
        mul_a = zi_q;
        mul_b = zi_q;
      end
      default: begin
        mul_a = zr_q;
        mul_b = zi_q;
      end
    endcase
  end

  mep_mul #(
    .ZW (ZW)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Scale products back; the cross term keeps one more bit for the factor two
  assign prod_re = prod[FRAC_BITS+ZW-1:FRAC_BITS];
  assign prod_im = prod[FRAC_BITS+ZW-2:FRAC_BITS-1];
  assign re_n    = p0_q - p1_q + cr_q;
  assign im_n    = prod_im + ci_q;
  assign esc_n   = (re_n > EscLim) || (re_n < NegLim) || (im_n > EscLim) || (im_n < NegLim);
  assign k_inc   = k_q + CB'(1);
  assign last_k  = (k_inc == max_iter_q);

  // Gray mapping bounds and range test
  assign lo             = (glo_q < ghi_q) ? glo_q : ghi_q;
  assign hi             = (glo_q < ghi_q) ? ghi_q : glo_q;
  assign gray_out_range = (lo == hi) || (GW'(k_q) < GW'(lo)) || (GW'(k_q) > GW'(hi));
  assign gray_div       = esc_q && !gray_out_range;
  assign div_num        = CfgW'(k_q) - lo;
  assign div_den        = hi - lo;
  assign div_start      = (state_q == ST_GRAY) && gray_div;

  mep_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .stat_o  (div_stat)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = (max_iter_q == '0) ? ST_GRAY : ST_ITER;
      end
      ST_ITER: begin
        if (ph_q == PhLast && (esc_n || last_k)) state_d = ST_GRAY;
      end
      ST_GRAY: begin
        state_d = gray_div ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (div_stat.done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and output register updates
  always_comb begin
    ph_d        = ph_q;
    k_d         = k_q;
    zr_d        = zr_q;
    zi_d        = zi_q;
    cr_d        = cr_q;
    ci_d        = ci_q;
    p0_d        = p0_q;
    p1_d        = p1_q;
    esc_d       = esc_q;
    gray_d      = gray_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cr_d  = cr_w[ZW-1:0];
          ci_d  = ci_w[ZW-1:0];
          zr_d  = cr_w[ZW-1:0];
          zi_d  = ci_w[ZW-1:0];
          k_d   = '0;
          esc_d = 1'b0;
          ph_d  = PhIssueRr;
        end
      end
      ST_ITER: begin
        if (ph_q == PhTakeRr) p0_d = prod_re;
        if (ph_q == PhTakeIi) p1_d = prod_re;
        if (ph_q == PhLast) begin
          zr_d  = re_n;
          zi_d  = im_n;
          k_d   = k_inc;
          esc_d = esc_n;
          ph_d  = PhIssueRr;
        end else begin
          ph_d = ph_q + 3'd1;
        end
      end
      ST_GRAY: begin
        gray_d = esc_q ? '0 : GrayW'(GrayMax);
      end
      ST_DIV: begin
        if (div_stat.done) gray_d = div_stat.quot;
      end
      ST_DONE: begin
        if (out_free) begin
          out_d.iter_count = CntOutW'(k_q);
          out_d.escaped    = esc_q;
          out_d.gray_level = gray_q;
          out_valid_d      = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= PhIssueRr;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= CB'(MaxIterReset);
      glo_q      <= CfgW'(GrayLoReset);
      ghi_q      <= CfgW'(GrayHiReset);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_MAX_ITER:  max_iter_q <= CB'(cfg_data_i);
        CFG_GRAY_LOW:  glo_q      <= cfg_data_i;
        CFG_GRAY_HIGH: ghi_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Iteration payload
  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    zr_q   <= zr_d;
    zi_q   <= zi_d;
    cr_q   <= cr_d;
    ci_q   <= ci_d;
    p0_q   <= p0_d;
    p1_q   <= p1_d;
    esc_q  <= esc_d;
    gray_q <= gray_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `MEP_ASSERT_NXT(a_accept_starts, accept, state_q == ST_ITER || state_q == ST_GRAY, "accepted item did not start")
  `MEP_ASSERT_IMP(a_iter_bounds, state_q == ST_ITER, k_q < max_iter_q && ph_q <= PhLast, "pass count or phase out of range")
  `MEP_ASSERT_IMP(a_inside_white, out_valid_o && !out_item_o.escaped, out_item_o.gray_level == GrayW'(GrayMax), "bounded point not mapped to full level")
  `MEP_ASSERT_IMP(a_div_active, state_q == ST_DIV, div_stat.busy || div_stat.done, "waiting on an idle divider")

endmodule

`default_nettype wire

FILE: tb/mandelbrot_escape_time_pixel_checker.sv
`timescale 1ns / 1ps

module mandelbrot_escape_time_pixel_checker
  import mep_pkg::*;
#(
  parameter int FRAC_BITS  = 29,
  parameter int COUNT_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  in_item_t        in_item_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  out_item_t       out_item_i,
  input  logic            cfg_valid_i,
  input  logic            cfg_ready_i,
  input  logic [1:0]      cfg_index_i,
  input  logic [CfgW-1:0] cfg_data_i,
  output int              fail_count_o,
  output int              pending_o
);

  // Width of the orbit registers: integer part plus fraction
  localparam int ZW = IntBits + FRAC_BITS;

  // Shadow copies of the configuration registers
  int unsigned max_iter = MaxIterReset;
  int unsigned gray_lo  = GrayLoReset;
  int unsigned gray_hi  = GrayHiReset;

  out_item_t expected_pixels[$];
  int        fails   = 0;
  int        pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  // Run the orbit of one point and map its count onto a gray level
  function automatic out_item_t escape_time(in_item_t pt);
    logic signed [ZW-1:0]   cr, ci, zr, zi, bound;
    logic signed [2*ZW-1:0] prr, pii, pri;
    int unsigned            k, lo, hi, gray;
    logic                   esc;
    out_item_t              res;
    if (FRAC_BITS >= InFrac) begin
      cr = $signed(pt.c_real) <<< (FRAC_BITS - InFrac);
      ci = $signed(pt.c_imag) <<< (FRAC_BITS - InFrac);
    end else begin
      cr = $signed(pt.c_real) >>> (InFrac - FRAC_BITS);
      ci = $signed(pt.c_imag) >>> (InFrac - FRAC_BITS);
    end
    bound = ZW'(EscapeLimit) <<< FRAC_BITS;
    zr    = cr;
    zi    = ci;
    k     = 0;
    esc   = 1'b0;
    while (k < max_iter && !esc) begin
      prr = zr * zr;
      pii = zi * zi;
      pri = zr * zi;
      zr  = (prr >>> FRAC_BITS) - (pii >>> FRAC_BITS) + cr;
      zi  = (pri >>> (FRAC_BITS - 1)) + ci;
      // exactly +-16 still counts as inside
      esc = (zr > bound) || (zr < -bound) || (zi > bound) || (zi < -bound);
      k++;
    end
    gray = GrayMax;
    if (esc) begin
      lo = (gray_lo < gray_hi) ? gray_lo : gray_hi;
      hi = (gray_lo < gray_hi) ? gray_hi : gray_lo;
      if (lo == hi || k < lo || k > hi) begin
        gray = 0;
      end else begin
        gray = (GrayMax * (k - lo)) / (hi - lo);
      end
    end
    res.iter_count = CntOutW'(k);
    res.escaped    = esc;
    res.gray_level = GrayW'(gray);
    return res;
  endfunction

  // Track register writes, queue predictions, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      max_iter = MaxIterReset;
      gray_lo  = GrayLoReset;
      gray_hi  = GrayHiReset;
      expected_pixels.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MAX_ITER:  max_iter = 32'(cfg_data_i) & ((32'd1 << COUNT_BITS) - 1);
          CFG_GRAY_LOW:  gray_lo  = 32'(cfg_data_i);
          CFG_GRAY_HIGH: gray_hi  = 32'(cfg_data_i);
          default: ; // unused index: drop the write
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        expected_pixels.push_back(escape_time(in_item_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected result item: iter_count %0d escaped %0d gray_level %0d",
                 out_item_i.iter_count, out_item_i.escaped, out_item_i.gray_level);
          fails++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_item_i.iter_count !== want.iter_count) begin
            $error("iter_count: expected %0d, got %0d", want.iter_count,
                   out_item_i.iter_count);
            fails++;
          end
          if (out_item_i.escaped !== want.escaped) begin
            $error("escaped: expected %0d, got %0d", want.escaped, out_item_i.escaped);
            fails++;
          end
          if (out_item_i.gray_level !== want.gray_level) begin
            $error("gray_level: expected %0d, got %0d", want.gray_level,
                   out_item_i.gray_level);
            fails++;
          end
        end
      end
    end
    pending = expected_pixels.size();
  end

endmodule

FILE: tb/tb_mandelbrot_escape_time_pixel.sv
`timescale 1ns / 1ps

module tb_mandelbrot_escape_time_pixel;
  import mep_pkg::*;

  localparam int          FracBits      = 29;
  localparam int          CountBits     = 16;
  localparam logic [1:0]  CfgIdxUnused  = 2'd3;
  localparam logic signed [InW-1:0] MaxQ = 32'sh7FFF_FFFF;
  localparam logic signed [InW-1:0] MinQ = 32'sh8000_0000;
  localparam int          ResetCycles   = 5;
  localparam int          SettleCycles  = 8;
  localparam int          TailCycles    = 50;
  localparam int          BlocksPerMode = 4;
  localparam int          ItemsPerBlock = 45;
  localparam longint      TimeoutNs     = 64'd60_000_000;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  in_item_t        in_item = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  out_item_t       out_item;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [1:0]      cfg_index = '0;
  logic [CfgW-1:0] cfg_data = '0;
  int              fails;
  int              pending;

  int unsigned send_idle_pct  = 30;
  int unsigned recv_stall_pct = 54;

  mandelbrot_escape_time_pixel #(
    .FRAC_BITS (FracBits),
    .COUNT_BITS(CountBits)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  mandelbrot_escape_time_pixel_checker #(
    .FRAC_BITS (FracBits),
    .COUNT_BITS(CountBits)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_item_i  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fails),
    .pending_o   (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the result side at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic signed [InW-1:0] to_q(input real v);
    return InW'($rtoi(v * (2.0 ** InFrac)));
  endfunction

  // Offer one point, with random gaps, and hold it until taken
  task automatic send_pixel(input logic signed [InW-1:0] re,
                            input logic signed [InW-1:0] im);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{re, im};
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic reconfigure(input int unsigned mi, input int unsigned lo,
                             input int unsigned hi);
    drain();
    write_reg(CFG_MAX_ITER, CfgW'(mi));
    write_reg(CFG_GRAY_LOW, CfgW'(lo));
    write_reg(CFG_GRAY_HIGH, CfgW'(hi));
  endtask

  initial begin
    #(TimeoutNs);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned mi, glo, ghi, tmp;
    logic signed [InW-1:0] re, im;

    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Field extremes and the +-16 boundary under reset settings
    send_pixel('0, '0);
    send_pixel(MaxQ, '0);
    send_pixel(MinQ, '0);
    send_pixel('0, MaxQ);
    send_pixel('0, MinQ);
    send_pixel(MaxQ, MaxQ);
    send_pixel(MinQ, MinQ);
    send_pixel(MaxQ, MinQ);
    send_pixel(MinQ, MaxQ);
    send_pixel(to_q(3.625), to_q(0.875));
    send_pixel('0, to_q(-4.0));
    send_pixel(to_q(3.5), to_q(2.0));
    send_pixel(to_q(3.5), to_q(-2.0));
    send_pixel(to_q(-1.0), to_q(-4.0));
    send_pixel(to_q(-0.75), to_q(0.1));

    // Zero limit: no pass at all
    reconfigure(0, GrayLoReset, GrayHiReset);
    send_pixel('0, '0);
    send_pixel(MaxQ, MaxQ);

    // Equal gray bounds
    reconfigure(1, 5, 5);
    send_pixel(MaxQ, '0);
    send_pixel('0, '0);

    // Reversed bounds, counts below them, full-length orbit
    reconfigure(65535, 200, 2);
    send_pixel(MaxQ, '0);
    send_pixel(to_q(-0.75), to_q(0.1));
    send_pixel('0, '0);

    // Unused register index must leave the settings alone
    reconfigure(10, 65535, 0);
    write_reg(CfgIdxUnused, 16'hFFFF);
    send_pixel(to_q(-2.0), '0);
    send_pixel(to_q(1.0), '0);

    // Random settings and points, three idling modes
    for (int mode = 0; mode < 3; mode++) begin
      for (int blk = 0; blk < BlocksPerMode; blk++) begin
        case ($urandom_range(3))
          0:       mi = 1;
          1:       mi = $urandom_range(2, 30);
          2:       mi = $urandom_range(31, 150);
          default: mi = $urandom_range(151, 400);
        endcase
        case ($urandom_range(4))
          0: begin
            glo = $urandom_range(65535);
            ghi = $urandom_range(65535);
          end
          1: begin
            glo = $urandom_range(mi);
            ghi = glo;
          end
          default: begin
            glo = $urandom_range(mi / 2);
            ghi = $urandom_range(mi / 2, mi + 3);
          end
        endcase
        if ($urandom_range(1)) begin
          tmp = glo;
          glo = ghi;
          ghi = tmp;
        end
        reconfigure(mi, glo, ghi);
        case (mode)
          0: begin
            send_idle_pct  = 30;
            recv_stall_pct = 54;
          end
          1: begin
            send_idle_pct  = 54;
            recv_stall_pct = 30;
          end
          default: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
          end
        endcase
        repeat (ItemsPerBlock) begin
          case ($urandom_range(19))
            0, 1, 2, 3, 4: begin
              re = $urandom();
              im = $urandom();
            end
            17: begin
              re = $urandom_range(1) ? MaxQ : MinQ;
              im = $urandom();
            end
            18: begin
              re = $urandom();
              im = $urandom_range(1) ? MaxQ : MinQ;
            end
            19: begin
              // elephant-valley region: long orbits
              re = to_q(0.25) + InW'($urandom_range(134217728));
              im = InW'($urandom_range(67108864)) - 32'sd33554432;
            end
            default: begin
              // bounding box of the set
              re = InW'($urandom_range(1342177280)) - 32'sd1073741824;
              im = InW'($urandom_range(1342177280)) - 32'sd671088640;
            end
          endcase
          send_pixel(re, im);
        end
      end
    end

    drain();
    repeat (TailCycles) @(posedge clk);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
